// ===== rtl/hfd_pkg.sv =====
// Shared types and constants for the base-16 to binary double converter.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

	localparam int FRAC_IN_W  = 56;
	localparam int FRAC_OUT_W = 52;
	localparam int EXP_IN_W   = 7;
	localparam int EXP_OUT_W  = 11;
	localparam int LZ_W       = 6;

	// 4*(e-64) - lz - 1 + 1023 folds to 4*e + 766 - lz.
	localparam logic [EXP_OUT_W-1:0] EXP_OFFSET = 11'd766;

	// Beat after the leading-zero count.
	typedef struct packed {
		logic                 sign;
		logic [EXP_IN_W-1:0]  exponent;
		logic [FRAC_IN_W-1:0] fraction;
		logic [LZ_W-1:0]      lz;
		logic                 zero;
	} s1_t;

	// Beat after normalization.
	typedef struct packed {
		logic                 sign;
		logic [EXP_OUT_W-1:0] exponent;
		logic [FRAC_IN_W-1:0] mant;
		logic                 zero;
	} s2_t;

	// Finished result.
	typedef struct packed {
		logic                  sign;
		logic [EXP_OUT_W-1:0]  exponent;
		logic [FRAC_OUT_W-1:0] fraction;
	} s3_t;

endpackage

`default_nettype wire

// ===== rtl/hex_float_to_binary_double_top.sv =====
// Base-16 double to binary double converter, three-stage pipeline.
// An accepted input beat is registered in turn by hfd_lzc, hfd_norm and hfd_round; out_valid
// rises when it reaches the hfd_round register.
// Throughput: one beat per cycle. The pipeline holds as a whole while a result waits.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
// Depends on hfd_pkg, hfd_lzc, hfd_norm and hfd_round.
`timescale 1ns / 1ps
`default_nettype none

module hex_float_to_binary_double_top import hfd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  in_sign,
	input  wire logic [EXP_IN_W-1:0]   in_exponent,
	input  wire logic [FRAC_IN_W-1:0]  in_fraction,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_sign,
	output logic [EXP_OUT_W-1:0]       out_exponent,
	output logic [FRAC_OUT_W-1:0]      out_fraction
);

	logic en;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	s1_t  beat_s1;
	s2_t  beat_s2;
	s3_t  beat_s3;

	// All stages advance together unless the output beat is held.
	assign en       = !valid_s3 || out_ready;
	assign in_ready = en;

	hfd_lzc u_lzc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (in_valid),
		.sign     (in_sign),
		.exponent (in_exponent),
		.fraction (in_fraction),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	hfd_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2)
	);

	hfd_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.beat_s2  (beat_s2),
		.valid_s3 (valid_s3),
		.beat_s3  (beat_s3)
	);

	// Output port.
	assign out_valid    = valid_s3;
	assign out_sign     = beat_s3.sign;
	assign out_exponent = beat_s3.exponent;
	assign out_fraction = beat_s3.fraction;

endmodule

`default_nettype wire

// ===== rtl/hfd_lzc.sv =====
// Stage 1: leading-zero count of the 56-bit hex fraction and zero detect.
// Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfd_lzc import hfd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid,
	input  wire logic                 sign,
	input  wire logic [EXP_IN_W-1:0]  exponent,
	input  wire logic [FRAC_IN_W-1:0] fraction,
	output logic                      valid_s1,
	output s1_t                       beat_s1
);

	logic [LZ_W-1:0] lz;

	// Priority search: the highest set bit wins because it is visited last.
	always_comb begin
		lz = LZ_W'(FRAC_IN_W - 1);
		for (int i = 0; i < FRAC_IN_W; i++) begin
			if (fraction[i]) begin
				lz = LZ_W'(FRAC_IN_W - 1 - i);
			end
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			beat_s1.sign     <= sign;
			beat_s1.exponent <= exponent;
			beat_s1.fraction <= fraction;
			beat_s1.lz       <= lz;
			beat_s1.zero     <= (fraction == '0);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hfd_norm.sv =====
// Stage 2: left shift by the leading-zero count and binary exponent.
// Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfd_norm import hfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s1,
	input  s1_t       beat_s1,
	output logic      valid_s2,
	output s2_t       beat_s2
);

	logic [FRAC_IN_W-1:0] mant;
	logic [EXP_OUT_W-1:0] bexp;

	// Barrel shift brings the leading one to the top bit.
	assign mant = beat_s1.fraction << beat_s1.lz;

	// Biased exponent before any rounding carry.
	assign bexp = {2'b00, beat_s1.exponent, 2'b00} + EXP_OFFSET
		- {{(EXP_OUT_W - LZ_W){1'b0}}, beat_s1.lz};

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			beat_s2.sign     <= beat_s1.sign;
			beat_s2.exponent <= bexp;
			beat_s2.mant     <= mant;
			beat_s2.zero     <= beat_s1.zero;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hfd_round.sv =====
// Stage 3: half-up rounding, carry into the exponent and the zero case.
// Depends on hfd_pkg; its register is the output register of the block.
`timescale 1ns / 1ps
`default_nettype none

module hfd_round import hfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s2,
	input  s2_t       beat_s2,
	output logic      valid_s3,
	output s3_t       beat_s3
);

	logic [FRAC_OUT_W:0]   sum;
	logic [EXP_OUT_W-1:0]  rexp;
	logic [FRAC_OUT_W-1:0] rfrac;

	// Keep the 52 bits below the leading one and add the highest dropped bit.
	assign sum = {1'b0, beat_s2.mant[FRAC_IN_W-2:FRAC_IN_W-1-FRAC_OUT_W]}
		+ {{FRAC_OUT_W{1'b0}}, beat_s2.mant[FRAC_IN_W-2-FRAC_OUT_W]};

	// A carry out leaves the low bits at zero and bumps the exponent.
	always_comb begin
		if (beat_s2.zero) begin
			rexp  = '0;
			rfrac = '0;
		end else begin
			rexp  = beat_s2.exponent + {{(EXP_OUT_W - 1){1'b0}}, sum[FRAC_OUT_W]};
			rfrac = sum[FRAC_OUT_W-1:0];
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			beat_s3.sign     <= beat_s2.sign;
			beat_s3.exponent <= rexp;
			beat_s3.fraction <= rfrac;
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for hex_float_to_binary_double_top.
// Depends on hfd_pkg and the converter RTL; a scoreboard class predicts each conversion.
`timescale 1ns / 1ps

module tb;
	import hfd_pkg::*;

	localparam int HEX_BIAS   = 64;
	localparam int BIN_BIAS   = 1023;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 8;
	localparam int MAX_PRINTS = 40;
	localparam int RANDOM_NUMBERS = 950;

	// Expected conversions in flight, and the checks on finished doubles.
	class double_scoreboard;
		s3_t expected_q[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned zeros;
		int unsigned carries;

		function new();
			mismatches = 0;
			checked = 0;
			zeros = 0;
			carries = 0;
		endfunction

		// Normalize, round half-up on the highest dropped bit, fix up the exponent.
		function s3_t convert(logic s, logic [EXP_IN_W-1:0] e, logic [FRAC_IN_W-1:0] f);
			s3_t r;
			int lz;
			int bx;
			logic [FRAC_IN_W-1:0] m;
			logic [FRAC_OUT_W:0] sum;
			r.sign = s;
			r.exponent = '0;
			r.fraction = '0;
			if (f == '0) begin
				zeros++;
			end else begin
				lz = 0;
				while (!f[FRAC_IN_W-1-lz])
					lz++;
				m = f << lz;
				sum = {1'b0, m[FRAC_IN_W-2:3]} + m[2];
				bx = 4 * (int'(e) - HEX_BIAS) - lz - 1 + BIN_BIAS;
				if (sum[FRAC_OUT_W]) begin
					sum = '0;
					bx++;
					carries++;
				end
				r.exponent = bx[EXP_OUT_W-1:0];
				r.fraction = sum[FRAC_OUT_W-1:0];
			end
			return r;
		endfunction

		function void note_input(logic s, logic [EXP_IN_W-1:0] e, logic [FRAC_IN_W-1:0] f);
			expected_q.push_back(convert(s, e, f));
		endfunction

		function void report_mismatch(string what);
			if (mismatches < MAX_PRINTS)
				$display("%0t ERROR: %s", $realtime, what);
			mismatches++;
		endfunction

		function void check_result(logic s, logic [EXP_OUT_W-1:0] e,
				logic [FRAC_OUT_W-1:0] f);
			s3_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat s=%0b e=%0d f=%h", s, e, f));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (s !== want.sign)
				report_mismatch($sformatf("sign %0b, want %0b", s, want.sign));
			if (e !== want.exponent)
				report_mismatch($sformatf("exponent %0d, want %0d", e, want.exponent));
			if (f !== want.fraction)
				report_mismatch($sformatf("fraction %h, want %h", f, want.fraction));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 in_sign = 1'b0;
	logic [EXP_IN_W-1:0]  in_exponent = '0;
	logic [FRAC_IN_W-1:0] in_fraction = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 out_sign;
	logic [EXP_OUT_W-1:0] out_exponent;
	logic [FRAC_OUT_W-1:0] out_fraction;

	bit no_idle = 1'b0;
	int idle_cycles = 0;
	double_scoreboard sb = new();

	hex_float_to_binary_double_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_sign      (in_sign),
		.in_exponent  (in_exponent),
		.in_fraction  (in_fraction),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_sign     (out_sign),
		.out_exponent (out_exponent),
		.out_fraction (out_fraction)
	);

	// Free-running 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Beat monitors and the watchdog; values read here are the ones before the edge.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_input(in_sign, in_exponent, in_fraction);
		if (out_valid && out_ready)
			sb.check_result(out_sign, out_exponent, out_fraction);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: stalls a random number of cycles before taking each result beat.
	initial begin
		int stall;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Present one number after a random gap and hold it until accepted.
	task automatic send_number(input logic s, input logic [EXP_IN_W-1:0] e,
			input logic [FRAC_IN_W-1:0] f);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_sign <= s;
		in_exponent <= e;
		in_fraction <= f;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [FRAC_IN_W-1:0] random_fraction();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[FRAC_IN_W-1:0];
	endfunction

	// Random numbers, weighted toward zeros, rounding carries and varied leading zeros.
	task automatic send_random(input int count);
		int kind;
		logic [FRAC_IN_W-1:0] f;
		for (int i = 0; i < count; i++) begin
			no_idle = ((i / 120) % 4) == 3;
			kind = $urandom_range(0, 9);
			f = random_fraction();
			case (kind)
				0: f = '0;
				1: begin
					f = {{(FRAC_IN_W-2){1'b1}}, f[1:0]};
					f = f >> $urandom_range(0, 2);
				end
				2, 3, 4: begin
					f[FRAC_IN_W-1] = 1'b1;
					f = f >> $urandom_range(0, FRAC_IN_W - 1);
				end
				default: ;
			endcase
			send_number(1'($urandom_range(0, 1)), EXP_IN_W'($urandom_range(0, 127)), f);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed numbers: zeros, extremes, rounding edges and carries.
		send_number(1'b0, 7'd0, 56'h0);
		send_number(1'b1, 7'd127, 56'h0);
		send_number(1'b1, 7'd64, 56'h0);
		send_number(1'b0, 7'd0, 56'h1);
		send_number(1'b1, 7'd127, 56'hFF_FFFF_FFFF_FFFF);
		send_number(1'b0, 7'd64, 56'h80_0000_0000_0000);
		send_number(1'b0, 7'd65, 56'h10_0000_0000_0000);
		send_number(1'b0, 7'd64, 56'h80_0000_0000_0004);
		send_number(1'b1, 7'd64, 56'h80_0000_0000_0003);
		send_number(1'b0, 7'd30, 56'h3F_FFFF_FFFF_FFFF);
		send_number(1'b0, 7'd90, 56'h7F_FFFF_FFFF_FFFC);
		send_number(1'b1, 7'd0, 56'h12_3456_789A_BCDE);
		send_number(1'b0, 7'd1, 56'h00_0000_0100_0000);
		send_number(1'b0, 7'd100, 56'h00_0000_FFFF_FFFF);
		send_number(1'b1, 7'd127, 56'h00_0000_0000_0007);
		send_number(1'b0, 7'd85, 56'hAA_AAAA_AAAA_AAAA);
		send_number(1'b1, 7'd42, 56'h55_5555_5555_5555);
		send_number(1'b0, 7'd63, 56'h0F_FFFF_FFFF_FFF8);
		send_number(1'b1, 7'd127, 56'h80_0000_0000_0000);
		send_number(1'b0, 7'd0, 56'h80_0000_0000_0000);

		send_random(RANDOM_NUMBERS);
		in_valid <= 1'b0;

		// Drain the pipeline, then keep watching for stray beats before the summary.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Checked %0d converted doubles, %0d of them zeros and %0d rounding carries,",
			sb.checked, sb.zeros, sb.carries);
		$display("with random gaps on both sides and stretches at full rate.");
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
